// ===== design/sobb_pkg.sv =====
// ----------------------------------------------------------------------------
// sobb_pkg
// shared types and constants of the segment / oriented box overlap test
// ----------------------------------------------------------------------------
package sobb_pkg;

    localparam int NUM_STAGES = 6;

    localparam int VEC_W      = 48;
    localparam int HALF_LEN_W = 15;
    localparam int S_TDATA_W  = 352;
    localparam int M_TDATA_W  = 8;

    // input transaction layout, lowest bit first
    localparam int OFS_SEG_CENTER = 0;
    localparam int OFS_SEG_DIR    = 48;
    localparam int OFS_HALF_LEN   = 96;
    localparam int OFS_BOX_CENTER = 111;
    localparam int OFS_AXIS_U     = 159;
    localparam int OFS_AXIS_V     = 207;
    localparam int OFS_AXIS_W     = 255;
    localparam int OFS_HALF_SIZES = 303;

    typedef struct packed {
        logic [NUM_STAGES-1:0] ld;
        logic [NUM_STAGES-1:0] vld;
    } t_pipe_ctl;

endpackage

// ===== design/sobb_pipe_ctl.sv =====
// ----------------------------------------------------------------------------
// sobb_pipe_ctl
// valid bits and per-stage load enables of the overlap test pipeline
// ----------------------------------------------------------------------------
module sobb_pipe_ctl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_out_ready,
    output sobb_pkg::t_pipe_ctl   o_ctl
);

    localparam int NS = sobb_pkg::NUM_STAGES;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] n_vld;
    logic [NS-1:0] ld;

    // a stage loads when it is empty or its successor loads
    always_comb begin
        ld[NS-1] = !r_vld[NS-1] || i_out_ready;
        for (int s = NS - 2; s >= 0; s--) begin
            ld[s] = !r_vld[s] || ld[s+1];
        end
        n_vld = (ld & {r_vld[NS-2:0], i_in_valid}) | (~ld & r_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.ld  = ld;
    assign o_ctl.vld = r_vld;

endmodule

// ===== design/segment_obb_overlap_test.sv =====
// ----------------------------------------------------------------------------
// segment_obb_overlap_test
// separating axis test of one 3d segment against one oriented box
// ----------------------------------------------------------------------------
// usage:
//   slave stream: one transaction carries a segment (center, direction, half
//   length) and a box (center, three axes, three half extents).
//   master stream: one transaction per input, tdata[0] = 1 on overlap.
//   the accepting edge loads the first of six register stages (unpack and
//   d.a products, diff products, dot sums, split products, wide sums,
//   compares). throughput is one transaction per cycle while the receiver
//   is ready. each stage holds its item while the next one is full, so a
//   stall of the receiver fills the pipeline and drops tready only when all
//   six stages hold an item; bubbles are squeezed out meanwhile.
//   reset empties the pipeline; no result is shown until a new input arrives.
//   COMPONENT_WIDTH sets the packed component width of every vector field
//   and the internal arithmetic widths; all products are exact.
// ----------------------------------------------------------------------------
module segment_obb_overlap_test #(
    parameter int COMPONENT_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // seg_center, seg_direction, seg_half_length, box_center, box_axis_u,
    // box_axis_v, box_axis_w, box_half_sizes, one zero pad bit
    input  logic [sobb_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // overlaps, seven zero pad bits
    output logic [sobb_pkg::M_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int NS   = sobb_pkg::NUM_STAGES;
    localparam int VW   = sobb_pkg::VEC_W;
    localparam int EW   = sobb_pkg::HALF_LEN_W;
    localparam int W    = COMPONENT_WIDTH;
    localparam int F    = W - 2;
    localparam int PW   = (3 * W > VW) ? 3 * W : VW;
    localparam int DW   = W + 1;
    localparam int PDW  = 2 * W;
    localparam int ADW  = 2 * W + 2;
    localparam int PXW  = 2 * W + 1;
    localparam int XSW  = 2 * W + 3;
    localparam int PCW  = 2 * W + 1;
    localparam int CRW  = 2 * W + 2;
    localparam int AHW  = ADW - W;
    localparam int AEHW = AHW + EW;
    localparam int AELW = W + EW;
    localparam int AHHW = AHW + W;
    localparam int ALHW = 2 * W;
    localparam int CHW  = 2 * W + 2;
    localparam int CLW  = 2 * W + 1;
    localparam int CDW  = 3 * W + 4;
    localparam int BLW  = XSW + F;
    localparam int BRW  = ((3 * W - 4 > ADW + EW) ? 3 * W - 4 : ADW + EW) + 1;
    localparam int XRW  = 3 * W + 3;
    localparam int CMPW = (BLW > BRW) ? BLW : BRW;
    localparam int CSW  = 3 * W + 6;

    sobb_pkg::t_pipe_ctl ctl;

    sobb_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_ctl       (ctl)
    );

    assign o_s_axis_tready = ctl.ld[0];
    assign o_m_axis_tvalid = ctl.vld[NS-1];

    // ------------------------------------------------------------------
    // stage 1: unpack, center difference, direction . axis products
    // ------------------------------------------------------------------
    logic [PW-1:0] ex_sc, ex_sd, ex_bc, ex_hs;
    logic [PW-1:0] ex_ax [3];

    assign ex_sc    = PW'(i_s_axis_tdata[sobb_pkg::OFS_SEG_CENTER +: VW]);
    assign ex_sd    = PW'(i_s_axis_tdata[sobb_pkg::OFS_SEG_DIR +: VW]);
    assign ex_bc    = PW'(i_s_axis_tdata[sobb_pkg::OFS_BOX_CENTER +: VW]);
    assign ex_hs    = PW'(i_s_axis_tdata[sobb_pkg::OFS_HALF_SIZES +: VW]);
    assign ex_ax[0] = PW'(i_s_axis_tdata[sobb_pkg::OFS_AXIS_U +: VW]);
    assign ex_ax[1] = PW'(i_s_axis_tdata[sobb_pkg::OFS_AXIS_V +: VW]);
    assign ex_ax[2] = PW'(i_s_axis_tdata[sobb_pkg::OFS_AXIS_W +: VW]);

    logic signed [W-1:0]   u_c [3];
    logic signed [W-1:0]   u_b [3];
    logic signed [W-1:0]   n_s1_d [3];
    logic signed [DW-1:0]  n_s1_diff [3];
    logic signed [W-1:0]   n_s1_ax [3][3];
    logic signed [PDW-1:0] n_s1_pd [3][3];
    logic [W-1:0]          n_s1_h [3];
    logic [EW-1:0]         n_s1_e;

    logic signed [W-1:0]   r_s1_d [3];
    logic signed [DW-1:0]  r_s1_diff [3];
    logic signed [W-1:0]   r_s1_ax [3][3];
    logic signed [PDW-1:0] r_s1_pd [3][3];
    logic [W-1:0]          r_s1_h [3];
    logic [EW-1:0]         r_s1_e;

    always_comb begin
        n_s1_e = i_s_axis_tdata[sobb_pkg::OFS_HALF_LEN +: EW];
        for (int i = 0; i < 3; i++) begin
            u_c[i]       = $signed(ex_sc[i*W +: W]);
            u_b[i]       = $signed(ex_bc[i*W +: W]);
            n_s1_d[i]    = $signed(ex_sd[i*W +: W]);
            n_s1_h[i]    = ex_hs[i*W +: W];
            n_s1_diff[i] = DW'(u_c[i]) - DW'(u_b[i]);
        end
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 3; i++) begin
                n_s1_ax[k][i] = $signed(ex_ax[k][i*W +: W]);
                n_s1_pd[k][i] = PDW'(n_s1_d[i]) * PDW'(n_s1_ax[k][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[0]) begin
            r_s1_d    <= n_s1_d;
            r_s1_diff <= n_s1_diff;
            r_s1_ax   <= n_s1_ax;
            r_s1_pd   <= n_s1_pd;
            r_s1_h    <= n_s1_h;
            r_s1_e    <= n_s1_e;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: d.a sums, diff . axis products, d x diff products
    // ------------------------------------------------------------------
    logic signed [ADW-1:0] n_s2_ads [3];
    logic signed [PXW-1:0] n_s2_px [3][3];
    logic signed [PCW-1:0] n_s2_pca [3];
    logic signed [PCW-1:0] n_s2_pcb [3];

    logic signed [ADW-1:0] r_s2_ads [3];
    logic signed [PXW-1:0] r_s2_px [3][3];
    logic signed [PCW-1:0] r_s2_pca [3];
    logic signed [PCW-1:0] r_s2_pcb [3];
    logic signed [W-1:0]   r_s2_ax [3][3];
    logic [W-1:0]          r_s2_h [3];
    logic [EW-1:0]         r_s2_e;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            int p;
            int q;
            p = (k == 2) ? 0 : k + 1;
            q = (k == 0) ? 2 : k - 1;
            n_s2_ads[k] = ADW'(r_s1_pd[k][0]) + ADW'(r_s1_pd[k][1]) + ADW'(r_s1_pd[k][2]);
            for (int i = 0; i < 3; i++) begin
                n_s2_px[k][i] = PXW'(r_s1_diff[i]) * PXW'(r_s1_ax[k][i]);
            end
            n_s2_pca[k] = PCW'(r_s1_d[p]) * PCW'(r_s1_diff[q]);
            n_s2_pcb[k] = PCW'(r_s1_d[q]) * PCW'(r_s1_diff[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[1]) begin
            r_s2_ads <= n_s2_ads;
            r_s2_px  <= n_s2_px;
            r_s2_pca <= n_s2_pca;
            r_s2_pcb <= n_s2_pcb;
            r_s2_ax  <= r_s1_ax;
            r_s2_h   <= r_s1_h;
            r_s2_e   <= r_s1_e;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: magnitudes of the box axis projections, cross vector
    // ------------------------------------------------------------------
    logic [ADW-1:0]        n_s3_ad [3];
    logic [XSW-1:0]        n_s3_xa [3];
    logic signed [CRW-1:0] n_s3_cr [3];

    logic [ADW-1:0]        r_s3_ad [3];
    logic [XSW-1:0]        r_s3_xa [3];
    logic signed [CRW-1:0] r_s3_cr [3];
    logic signed [W-1:0]   r_s3_ax [3][3];
    logic [W-1:0]          r_s3_h [3];
    logic [EW-1:0]         r_s3_e;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic signed [XSW-1:0] xs;
            xs = XSW'(r_s2_px[k][0]) + XSW'(r_s2_px[k][1]) + XSW'(r_s2_px[k][2]);
            n_s3_xa[k] = xs[XSW-1] ? XSW'(-xs) : XSW'(xs);
            n_s3_ad[k] = r_s2_ads[k][ADW-1] ? ADW'(-r_s2_ads[k]) : ADW'(r_s2_ads[k]);
            n_s3_cr[k] = CRW'(r_s2_pca[k]) - CRW'(r_s2_pcb[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[2]) begin
            r_s3_ad <= n_s3_ad;
            r_s3_xa <= n_s3_xa;
            r_s3_cr <= n_s3_cr;
            r_s3_ax <= r_s2_ax;
            r_s3_h  <= r_s2_h;
            r_s3_e  <= r_s2_e;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: split partial products of the radii and of cross . axis
    // ------------------------------------------------------------------
    logic [AEHW-1:0]       n_s4_aeh [3];
    logic [AELW-1:0]       n_s4_ael [3];
    logic [AHHW-1:0]       n_s4_hha [3];
    logic [ALHW-1:0]       n_s4_hla [3];
    logic [AHHW-1:0]       n_s4_hhb [3];
    logic [ALHW-1:0]       n_s4_hlb [3];
    logic signed [CHW-1:0] n_s4_cha [3][3];
    logic signed [CLW-1:0] n_s4_cla [3][3];

    logic [AEHW-1:0]       r_s4_aeh [3];
    logic [AELW-1:0]       r_s4_ael [3];
    logic [AHHW-1:0]       r_s4_hha [3];
    logic [ALHW-1:0]       r_s4_hla [3];
    logic [AHHW-1:0]       r_s4_hhb [3];
    logic [ALHW-1:0]       r_s4_hlb [3];
    logic signed [CHW-1:0] r_s4_cha [3][3];
    logic signed [CLW-1:0] r_s4_cla [3][3];
    logic [XSW-1:0]        r_s4_xa [3];
    logic [W-1:0]          r_s4_h [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            int p;
            int q;
            p = (k == 2) ? 0 : k + 1;
            q = (k == 0) ? 2 : k - 1;
            n_s4_aeh[k] = AEHW'(r_s3_ad[k][ADW-1:W]) * AEHW'(r_s3_e);
            n_s4_ael[k] = AELW'(r_s3_ad[k][W-1:0]) * AELW'(r_s3_e);
            n_s4_hha[k] = AHHW'(r_s3_ad[q][ADW-1:W]) * AHHW'(r_s3_h[p]);
            n_s4_hla[k] = ALHW'(r_s3_ad[q][W-1:0]) * ALHW'(r_s3_h[p]);
            n_s4_hhb[k] = AHHW'(r_s3_ad[p][ADW-1:W]) * AHHW'(r_s3_h[q]);
            n_s4_hlb[k] = ALHW'(r_s3_ad[p][W-1:0]) * ALHW'(r_s3_h[q]);
            for (int i = 0; i < 3; i++) begin
                n_s4_cha[k][i] = CHW'($signed(r_s3_cr[i][CRW-1:W])) * CHW'(r_s3_ax[k][i]);
                n_s4_cla[k][i] = CLW'($signed({1'b0, r_s3_cr[i][W-1:0]}))
                               * CLW'(r_s3_ax[k][i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[3]) begin
            r_s4_aeh <= n_s4_aeh;
            r_s4_ael <= n_s4_ael;
            r_s4_hha <= n_s4_hha;
            r_s4_hla <= n_s4_hla;
            r_s4_hhb <= n_s4_hhb;
            r_s4_hlb <= n_s4_hlb;
            r_s4_cha <= n_s4_cha;
            r_s4_cla <= n_s4_cla;
            r_s4_xa  <= r_s3_xa;
            r_s4_h   <= r_s3_h;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: projected distances and radii at full width
    // ------------------------------------------------------------------
    logic [BLW-1:0]        n_s5_bl [3];
    logic [BRW-1:0]        n_s5_br [3];
    logic [XRW-1:0]        n_s5_xr [3];
    logic signed [CDW-1:0] n_s5_cd [3];

    logic [BLW-1:0]        r_s5_bl [3];
    logic [BRW-1:0]        r_s5_br [3];
    logic [XRW-1:0]        r_s5_xr [3];
    logic signed [CDW-1:0] r_s5_cd [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_s5_bl[k] = BLW'(r_s4_xa[k]) << F;
            n_s5_br[k] = (BRW'(r_s4_h[k]) << (2 * F))
                       + (BRW'(r_s4_aeh[k]) << W)
                       + BRW'(r_s4_ael[k]);
            n_s5_xr[k] = (XRW'(r_s4_hha[k]) << W) + XRW'(r_s4_hla[k])
                       + (XRW'(r_s4_hhb[k]) << W) + XRW'(r_s4_hlb[k]);
            n_s5_cd[k] = (CDW'(r_s4_cha[k][0]) << W) + CDW'(r_s4_cla[k][0])
                       + (CDW'(r_s4_cha[k][1]) << W) + CDW'(r_s4_cla[k][1])
                       + (CDW'(r_s4_cha[k][2]) << W) + CDW'(r_s4_cla[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[4]) begin
            r_s5_bl <= n_s5_bl;
            r_s5_br <= n_s5_br;
            r_s5_xr <= n_s5_xr;
            r_s5_cd <= n_s5_cd;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: six axis compares, result register
    // ------------------------------------------------------------------
    logic n_s6_ovl;
    logic r_s6_ovl;

    always_comb begin
        logic sep;
        sep = 1'b0;
        for (int k = 0; k < 3; k++) begin
            logic signed [CSW-1:0] cds;
            logic signed [CSW-1:0] rs;
            logic signed [CSW-1:0] sm;
            cds = CSW'(r_s5_cd[k]);
            rs  = $signed(CSW'(r_s5_xr[k]));
            sm  = cds + rs;
            // |cd| > r either way round, ties overlap
            if ((cds > rs) || sm[CSW-1]) begin
                sep = 1'b1;
            end
            if (CMPW'(r_s5_bl[k]) > CMPW'(r_s5_br[k])) begin
                sep = 1'b1;
            end
        end
        n_s6_ovl = !sep;
    end

    always_ff @(posedge i_clk) begin
        if (ctl.ld[5]) begin
            r_s6_ovl <= n_s6_ovl;
        end
    end

    assign o_m_axis_tdata = {(sobb_pkg::M_TDATA_W - 1)'(0), r_s6_ovl};

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_acc = o_m_axis_tvalid && i_m_axis_tready;

`ifndef SYNTH
    // pipeline occupancy tracks accepted input and output transactions
    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(ctl.vld) == $countones($past(ctl.vld))
                                    + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("pipeline occupancy mismatch");

    // any empty stage lets the input side through
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&ctl.vld) |-> o_s_axis_tready)
        else $error("input stalled with an empty stage");

    // reset empties every stage
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (ctl.vld == '0))
        else $error("valid bit left after reset");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench of the segment / oriented box overlap test
// ----------------------------------------------------------------------------
// drives segment/box pairs on the slave stream with random gaps and stalls
// the master stream at random. a short table of hand-made pairs covers empty
// and degenerate shapes, extreme components, ties and cross axis separation.
// the random part is mostly rotated boxes near the segment, plus raw bit
// patterns and corner values. results are checked against an exact integer
// predictor of the separating axis test or a verdict fixed in the table.
// ----------------------------------------------------------------------------
module testbench;

    localparam int COMP_W      = 16;
    localparam int DIR_FRAC    = COMP_W - 2;
    localparam int RANDOM_PAIRS = 1150;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [15:0] Q14_ONE = 16'h4000;
    localparam logic [15:0] Q88_ONE = 16'h0100;

    typedef struct packed {
        logic [sobb_pkg::VEC_W-1:0]      seg_center;
        logic [sobb_pkg::VEC_W-1:0]      seg_dir;
        logic [sobb_pkg::HALF_LEN_W-1:0] half_len;
        logic [sobb_pkg::VEC_W-1:0]      box_center;
        logic [sobb_pkg::VEC_W-1:0]      axis_u;
        logic [sobb_pkg::VEC_W-1:0]      axis_v;
        logic [sobb_pkg::VEC_W-1:0]      axis_w;
        logic [sobb_pkg::VEC_W-1:0]      half_sizes;
    } t_seg_box;

    typedef enum logic [1:0] {FROM_PREDICTOR, KNOWN_MISS, KNOWN_HIT} t_verdict_src;

    typedef struct {
        t_seg_box     pair;
        t_verdict_src src;
    } t_pair_case;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           s_valid;
    logic                           o_s_axis_tready;
    logic [sobb_pkg::S_TDATA_W-1:0] s_data;
    logic                           o_m_axis_tvalid;
    logic                           m_ready;
    logic [sobb_pkg::M_TDATA_W-1:0] o_m_axis_tdata;

    bit         overlap_due [$];
    t_pair_case directed [$];
    bit         burst_mode = 1'b0;
    int         errors = 0;
    int         sent = 0;
    int         hits = 0;
    int         misses = 0;
    int         cycles = 0;

    segment_obb_overlap_test #(
        .COMPONENT_WIDTH (COMP_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [47:0] pack3(int x, int y, int z);
        return {z[15:0], y[15:0], x[15:0]};
    endfunction

    function automatic logic [sobb_pkg::S_TDATA_W-1:0] pack_pair(t_seg_box t);
        logic [sobb_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[sobb_pkg::OFS_SEG_CENTER +: sobb_pkg::VEC_W]    = t.seg_center;
        d[sobb_pkg::OFS_SEG_DIR +: sobb_pkg::VEC_W]       = t.seg_dir;
        d[sobb_pkg::OFS_HALF_LEN +: sobb_pkg::HALF_LEN_W] = t.half_len;
        d[sobb_pkg::OFS_BOX_CENTER +: sobb_pkg::VEC_W]    = t.box_center;
        d[sobb_pkg::OFS_AXIS_U +: sobb_pkg::VEC_W]        = t.axis_u;
        d[sobb_pkg::OFS_AXIS_V +: sobb_pkg::VEC_W]        = t.axis_v;
        d[sobb_pkg::OFS_AXIS_W +: sobb_pkg::VEC_W]        = t.axis_w;
        d[sobb_pkg::OFS_HALF_SIZES +: sobb_pkg::VEC_W]    = t.half_sizes;
        return d;
    endfunction

    function automatic longint comp_s(logic [47:0] v, int k);
        logic signed [15:0] c;
        c = v[COMP_W*k +: COMP_W];
        return longint'(c);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint dot3(longint x0, longint x1, longint x2,
                                    longint y0, longint y1, longint y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    // exact separating axis test, all terms fit in 64 bits at this width
    function automatic bit predict_overlap(t_seg_box t);
        longint c [3];
        longint d [3];
        longint b [3];
        longint ax [3][3];
        longint df [3];
        longint h [3];
        longint ad [3];
        longint cr [3];
        longint e, lhs, rhs;
        int p, q;
        e = longint'(t.half_len);
        for (int k = 0; k < 3; k++) begin
            c[k]     = comp_s(t.seg_center, k);
            d[k]     = comp_s(t.seg_dir, k);
            b[k]     = comp_s(t.box_center, k);
            ax[0][k] = comp_s(t.axis_u, k);
            ax[1][k] = comp_s(t.axis_v, k);
            ax[2][k] = comp_s(t.axis_w, k);
            h[k]     = longint'(t.half_sizes[COMP_W*k +: COMP_W]);
            df[k]    = c[k] - b[k];
        end
        for (int k = 0; k < 3; k++) begin
            ad[k] = mag(dot3(d[0], d[1], d[2], ax[k][0], ax[k][1], ax[k][2]));
            lhs = mag(dot3(df[0], df[1], df[2], ax[k][0], ax[k][1], ax[k][2])) <<< DIR_FRAC;
            rhs = (h[k] <<< (2 * DIR_FRAC)) + ad[k] * e;
            if (lhs > rhs) return 1'b0;
        end
        cr[0] = d[1] * df[2] - d[2] * df[1];
        cr[1] = d[2] * df[0] - d[0] * df[2];
        cr[2] = d[0] * df[1] - d[1] * df[0];
        for (int k = 0; k < 3; k++) begin
            p = (k + 1) % 3;
            q = (k + 2) % 3;
            lhs = mag(dot3(cr[0], cr[1], cr[2], ax[k][0], ax[k][1], ax[k][2]));
            rhs = ad[q] * h[p] + ad[p] * h[q];
            if (lhs > rhs) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_pair_case row(logic [47:0] sc, logic [47:0] sd, int e,
                                       logic [47:0] bc, logic [47:0] u, logic [47:0] v,
                                       logic [47:0] w, logic [47:0] hs, t_verdict_src src);
        t_pair_case r;
        r.pair = '{sc, sd, e[14:0], bc, u, v, w, hs};
        r.src  = src;
        return r;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [15:0] corner_comp();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [47:0] corner3();
        return {corner_comp(), corner_comp(), corner_comp()};
    endfunction

    function automatic int q14(real x);
        int v;
        v = $rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5));
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    function automatic real rand_angle();
        return $itor($urandom_range(0, 62831)) / 10000.0;
    endfunction

    function automatic int rand_pos(int span);
        return $urandom_range(0, 2 * span) - span;
    endfunction

    // rotated or axis-aligned box near the segment, so both verdicts come up often
    function automatic t_seg_box shaped_pair();
        t_seg_box t;
        real sa, ca, sb, cb, sc, cc, st, ct, sp, cp;
        int bx, by, bz, sgn;
        sa = $sin(rand_angle()); ca = $cos(rand_angle());
        sa = $sin(rand_angle());
        sb = $sin(rand_angle()); cb = $cos(rand_angle());
        sc = $sin(rand_angle()); cc = $cos(rand_angle());
        st = $sin(rand_angle()); ct = $cos(rand_angle());
        sp = $sin(rand_angle()); cp = $cos(rand_angle());
        // keep sin/cos pairs consistent
        ca = $sqrt(1.0 - sa * sa); cb = $sqrt(1.0 - sb * sb);
        cc = $sqrt(1.0 - sc * sc); ct = $sqrt(1.0 - st * st);
        cp = $sqrt(1.0 - sp * sp);
        if ($urandom_range(0, 1)) ca = -ca;
        if ($urandom_range(0, 1)) ct = -ct;
        if ($urandom_range(0, 7) == 0) begin
            // aligned box and axis-parallel segment: exact ties are likely
            sgn = $urandom_range(0, 1) ? 16384 : -16384;
            t.axis_u = pack3(16384, 0, 0);
            t.axis_v = pack3(0, 16384, 0);
            t.axis_w = pack3(0, 0, 16384);
            case ($urandom_range(0, 2))
                0: t.seg_dir = pack3(sgn, 0, 0);
                1: t.seg_dir = pack3(0, sgn, 0);
                default: t.seg_dir = pack3(0, 0, sgn);
            endcase
        end else begin
            t.axis_u = pack3(q14(ca * cb), q14(sa * cb), q14(-sb));
            t.axis_v = pack3(q14(ca * sb * sc - sa * cc), q14(sa * sb * sc + ca * cc),
                             q14(cb * sc));
            t.axis_w = pack3(q14(ca * sb * cc + sa * sc), q14(sa * sb * cc - ca * sc),
                             q14(cb * cc));
            t.seg_dir = pack3(q14(ct * cp), q14(st * cp), q14(sp));
        end
        bx = rand_pos(2048); by = rand_pos(2048); bz = rand_pos(2048);
        t.box_center = pack3(bx, by, bz);
        t.seg_center = pack3(bx + rand_pos(1536), by + rand_pos(1536), bz + rand_pos(1536));
        t.half_len   = 15'($urandom_range(0, 1536));
        t.half_sizes = pack3($urandom_range(0, 1024), $urandom_range(0, 1024),
                             $urandom_range(0, 1024));
        return t;
    endfunction

    function automatic t_seg_box random_pair();
        t_seg_box t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            t = shaped_pair();
        end else if (r < 88) begin
            t = '{rand48(), rand48(), 15'($urandom), rand48(), rand48(), rand48(),
                  rand48(), rand48()};
        end else begin
            t = '{corner3(), corner3(), 15'($urandom_range(0, 1) ? 15'h7FFF : 15'($urandom)),
                  corner3(), corner3(), corner3(), corner3(), corner3()};
        end
        return t;
    endfunction

    task automatic send_pair(t_seg_box t, t_verdict_src src);
        int gap;
        bit verdict;
        gap = burst_mode ? 0 : gap_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= pack_pair(t);
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        case (src)
            KNOWN_HIT:  verdict = 1'b1;
            KNOWN_MISS: verdict = 1'b0;
            default:    verdict = predict_overlap(t);
        endcase
        overlap_due.push_back(verdict);
        sent++;
    endtask

    // result transaction check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (overlap_due.size() == 0) begin
                $display("%0t: result with no pending pair, actual overlaps %0b",
                         $time, o_m_axis_tdata[0]);
                errors++;
            end else begin
                automatic bit want = overlap_due.pop_front();
                if (o_m_axis_tdata[0] !== want) begin
                    $display("%0t: overlaps mismatch, expected %0b actual %0b",
                             $time, want, o_m_axis_tdata[0]);
                    errors++;
                end
                if (want) hits++;
                else misses++;
            end
        end
    end

    // receiver backpressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (!burst_mode && $urandom_range(0, 2) == 0) stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     overlap_due.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        logic [47:0] ux, uy, uz, hs1, zero3, diag;
        ux    = pack3(Q14_ONE, 0, 0);
        uy    = pack3(0, Q14_ONE, 0);
        uz    = pack3(0, 0, Q14_ONE);
        hs1   = pack3(Q88_ONE, Q88_ONE, Q88_ONE);
        zero3 = '0;
        diag  = pack3(11585, -11585, 0);

        directed.push_back(row(zero3, zero3, 0, zero3, zero3, zero3, zero3, zero3, KNOWN_HIT));
        directed.push_back(row(zero3, ux, 256, zero3, ux, uy, uz, hs1, KNOWN_HIT));
        directed.push_back(row(pack3(2560, 0, 0), ux, 256, zero3, ux, uy, uz, hs1, KNOWN_MISS));
        directed.push_back(row(pack3(-2560, 0, 0), ux, 256, zero3, ux, uy, uz, hs1, KNOWN_MISS));
        // touching end to face
        directed.push_back(row(pack3(512, 0, 0), ux, 256, zero3, ux, uy, uz, hs1, KNOWN_HIT));
        directed.push_back(row(pack3(513, 0, 0), ux, 256, zero3, ux, uy, uz, hs1, KNOWN_MISS));
        directed.push_back(row(pack3(0, 0, -2560), uz, 256, zero3, ux, uy, uz, hs1,
                               KNOWN_MISS));
        directed.push_back(row(pack3(2560, 0, 0), ux, 32767, zero3, ux, uy, uz, hs1,
                               KNOWN_HIT));
        // only the cross axis separates
        directed.push_back(row(pack3(512, 512, 0), diag, 512, zero3, ux, uy, uz, hs1,
                               FROM_PREDICTOR));
        directed.push_back(row(pack3(512, 512, 0), diag, 512, zero3, ux, uy, uz,
                               pack3(768, 768, 256), FROM_PREDICTOR));
        directed.push_back(row({3{16'h7FFF}}, {3{16'h7FFF}}, 32767, {3{16'h7FFF}},
                               {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}},
                               FROM_PREDICTOR));
        directed.push_back(row({3{16'h8000}}, {3{16'h8000}}, 0, {3{16'h8000}},
                               {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}},
                               FROM_PREDICTOR));
        directed.push_back(row({3{16'hFFFF}}, {3{16'hFFFF}}, 32767, {3{16'hFFFF}},
                               {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}}, {3{16'hFFFF}},
                               FROM_PREDICTOR));
        directed.push_back(row({3{16'h7FFF}}, {3{16'h8000}}, 32767, {3{16'h8000}}, ux, uy, uz,
                               {3{16'hFFFF}}, FROM_PREDICTOR));
        directed.push_back(row({3{16'h8000}}, zero3, 0, {3{16'h7FFF}}, ux, uy, uz, zero3,
                               KNOWN_MISS));
        // degenerate segment, point inside
        directed.push_back(row(pack3(128, 0, 0), zero3, 0, zero3, ux, uy, uz, hs1, KNOWN_HIT));
        directed.push_back(row(pack3(3000, -700, 90), pack3(100, 200, 300), 1000, zero3,
                               zero3, zero3, zero3, hs1, KNOWN_HIT));
        // zero-size box, segment through its center
        directed.push_back(row(zero3, ux, 256, zero3, ux, uy, uz, zero3, KNOWN_HIT));
        // unnormalized direction and axes
        directed.push_back(row(pack3(700, 0, 0), pack3(16'h7FFF, 0, 0), 200, zero3, ux, uy,
                               uz, hs1, FROM_PREDICTOR));
        directed.push_back(row(pack3(300, 300, 0), diag, 100, zero3, pack3(8192, 0, 0),
                               pack3(0, 8192, 0), pack3(0, 0, 8192), hs1, FROM_PREDICTOR));
        directed.push_back(row(pack3(400, 400, 400), pack3(9459, 9459, 9459), 300, zero3,
                               ux, uy, uz, hs1, FROM_PREDICTOR));

        i_rst_n <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[n]) send_pair(directed[n].pair, directed[n].src);
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
            send_pair(random_pair(), FROM_PREDICTOR);
        end
        burst_mode = 1'b0;
        s_valid <= 1'b0;

        while (overlap_due.size() != 0) @(posedge i_clk);
        repeat (sobb_pkg::NUM_STAGES + 10) @(posedge i_clk);

        $display("covered %0d segment/box pairs (%0d from the table) in %0d cycles",
                 sent, directed.size(), cycles);
        $display("verdicts seen: %0d overlap, %0d separated", hits, misses);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
